@@ rtl/dfl_pkg.sv @@
// Shared types and constants for the decimal field to character display writer.
// Used by dfl_cell, dfl_ser and decimal_field_to_char_lcd.
package dfl_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned DigitW = 4;

  localparam logic [1:0] RowLine1 = 2'd1;
  localparam logic [1:0] RowLine2 = 2'd2;

  localparam logic [7:0] CmdSetAddr = 8'h80;
  localparam logic [7:0] Line2Offset = 8'h40;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero = 8'h30;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [16:0] DivTenMul = 17'd52429;
  localparam int unsigned DivTenShift = 19;

  typedef struct packed {
    logic [1:0] row;
    logic [5:0] column;
    logic       neg;
    logic [2:0] count;
  } item_hdr_t;

endpackage

@@ rtl/decimal_field_to_char_lcd.sv @@
// Top level: signed number to character display bytes (address, sign, digits).
// Depends on dfl_pkg, dfl_cell and dfl_ser.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid_i / in_ready_o  | row_i, column_i, value_i, digit_count_i
//  output   | out_valid_o / out_ready_i| is_data_o, out_byte_o, last_o
//
// A transaction passes through MAX_DIGITS registered digit cells into the serializer.
// The serializer emits one byte per cycle while out_ready_i is high, up to MAX_DIGITS + 2
// bytes per transaction; it loads the next transaction as the last byte of the current one
// is taken, and a transaction with an empty run emits no bytes.
// The cells take new transactions while the serializer still drains an earlier one.
// Output stalls back up through the cells; reset clears all valid flags.
module decimal_field_to_char_lcd #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  row_i,
  input  logic [5:0]  column_i,
  input  logic [15:0] value_i,
  input  logic [2:0]  digit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_data_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);
  import dfl_pkg::*;

  localparam int unsigned DigitsW = MAX_DIGITS * DigitW;

  logic                valid_c [MAX_DIGITS+1];
  logic                ready_c [MAX_DIGITS+1];
  item_hdr_t           hdr_c   [MAX_DIGITS+1];
  logic [ValueW-1:0]   value_c [MAX_DIGITS+1];
  logic [DigitsW-1:0]  digits_c [MAX_DIGITS+1];

  assign hdr_c[0].row = row_i;
  assign hdr_c[0].column = column_i;
  assign hdr_c[0].neg = value_i[ValueW-1];
  assign hdr_c[0].count = (int'(digit_count_i) > MAX_DIGITS) ? 3'(MAX_DIGITS) : digit_count_i;
  assign value_c[0] = value_i[ValueW-1] ? (~value_i + 16'd1) : value_i;
  assign digits_c[0] = '0;

  assign valid_c[0] = in_valid_i;
  assign in_ready_o = ready_c[0];

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    dfl_cell #(
      .MAX_DIGITS(MAX_DIGITS),
      .IDX       (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[g]),
      .ready_o (ready_c[g]),
      .hdr_i   (hdr_c[g]),
      .value_i (value_c[g]),
      .digits_i(digits_c[g]),
      .valid_o (valid_c[g+1]),
      .ready_i (ready_c[g+1]),
      .hdr_o   (hdr_c[g+1]),
      .value_o (value_c[g+1]),
      .digits_o(digits_c[g+1])
    );
  end

  dfl_ser #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_c[MAX_DIGITS]),
    .ready_o   (ready_c[MAX_DIGITS]),
    .hdr_i     (hdr_c[MAX_DIGITS]),
    .digits_i  (digits_c[MAX_DIGITS]),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .is_data_o (is_data_o),
    .out_byte_o(out_byte_o),
    .last_o    (last_o)
  );

endmodule

@@ rtl/dfl_cell.sv @@
// One digit cell: peels the lowest decimal digit off the value and hands the quotient on.
// Depends on dfl_pkg.
module dfl_cell #(
  parameter int unsigned MAX_DIGITS = 5,
  parameter int unsigned IDX = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  dfl_pkg::item_hdr_t                    hdr_i,
  input  logic [dfl_pkg::ValueW-1:0]            value_i,
  input  logic [MAX_DIGITS*dfl_pkg::DigitW-1:0] digits_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output dfl_pkg::item_hdr_t                    hdr_o,
  output logic [dfl_pkg::ValueW-1:0]            value_o,
  output logic [MAX_DIGITS*dfl_pkg::DigitW-1:0] digits_o
);
  import dfl_pkg::*;

  localparam int unsigned ProdW = ValueW + 17;

  logic                           valid_q;
  item_hdr_t                      hdr_q;
  logic [ValueW-1:0]              value_q, value_d;
  logic [MAX_DIGITS*DigitW-1:0]   digits_q, digits_d;
  logic [ProdW-1:0]               prod;
  logic [ValueW-1:0]              quot;
  logic [DigitW-1:0]              rem;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    prod = {17'd0, value_i} * {{(ProdW-17){1'b0}}, DivTenMul};
    quot = prod[DivTenShift +: ValueW];
    rem = value_i[DigitW-1:0] - {quot[DigitW-4:0], 3'b000} - {quot[DigitW-2:0], 1'b0};
    value_d = quot;
    digits_d = digits_i;
    digits_d[IDX*DigitW +: DigitW] = rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      hdr_q <= hdr_i;
      value_q <= value_d;
      digits_q <= digits_d;
    end
  end

  assign valid_o = valid_q;
  assign hdr_o = hdr_q;
  assign value_o = value_q;
  assign digits_o = digits_q;

endmodule

@@ rtl/dfl_ser.sv @@
// Byte serializer: turns one converted item into its run of command and data bytes.
// Depends on dfl_pkg.
module dfl_ser #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  dfl_pkg::item_hdr_t                    hdr_i,
  input  logic [MAX_DIGITS*dfl_pkg::DigitW-1:0] digits_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic                                  is_data_o,
  output logic [7:0]                            out_byte_o,
  output logic                                  last_o
);
  import dfl_pkg::*;

  localparam int unsigned NumSlots = MAX_DIGITS + 2;

  logic [NumSlots-1:0] mask_q, mask_d;
  logic [7:0]          bytes_q [NumSlots];
  logic [7:0]          bytes_d [NumSlots];
  logic [NumSlots-1:0] pick;
  logic [NumSlots-1:0] rest;
  logic [7:0]          addr;
  logic                load;
  logic [7:0]          sel_byte;

  always_comb begin
    pick = mask_q & (~mask_q + {{(NumSlots-1){1'b0}}, 1'b1});
    rest = mask_q & ~pick;
    last_o = (rest == '0);
    valid_o = (mask_q != '0);
    is_data_o = !pick[0];
    sel_byte = '0;
    for (int i = 0; i < NumSlots; i++) begin
      sel_byte = sel_byte | (bytes_q[i] & {8{pick[i]}});
    end
    out_byte_o = sel_byte;
  end

  assign ready_o = !valid_o || (ready_i && last_o);
  assign load = valid_i && ready_o;

  always_comb begin
    addr = CmdSetAddr | ({2'b00, hdr_i.column} - 8'd1);
    if (hdr_i.row == RowLine2) begin
      addr = CmdSetAddr | ({2'b00, hdr_i.column} - 8'd1 + Line2Offset);
    end
    bytes_d[0] = addr;
    bytes_d[1] = CharMinus;
    mask_d[0] = (hdr_i.row == RowLine1) || (hdr_i.row == RowLine2);
    mask_d[1] = hdr_i.neg;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      bytes_d[j+2] = CharZero;
      mask_d[j+2] = (int'(hdr_i.count) > j);
      for (int k = 0; k < MAX_DIGITS; k++) begin
        if (int'(hdr_i.count) - 1 - j == k) begin
          bytes_d[j+2] = CharZero | {4'd0, digits_i[k*DigitW +: DigitW]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load) begin
      mask_q <= mask_d;
    end else if (valid_o && ready_i) begin
      mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q <= bytes_d;
    end
  end

endmodule
